// ===== rtl/pbsa_pkg.sv =====
// shared types, constants and command/status bundles of the paged bitmap slot allocator
`timescale 1ns / 1ps

package pbsa_pkg;

   localparam int MAX_PAGES      = 16;
   localparam int SLOTS_PER_PAGE = 128;
   localparam int PAGE_W         = $clog2(MAX_PAGES);
   localparam int SLOT_W         = $clog2(SLOTS_PER_PAGE);
   localparam int COUNT_W        = $clog2(MAX_PAGES + 1);

   typedef logic [SLOTS_PER_PAGE-1:0] occ_type;
   typedef logic [PAGE_W-1:0]         page_type;
   typedef logic [SLOT_W-1:0]         slot_type;
   typedef logic [COUNT_W-1:0]        count_type;

   typedef enum logic {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_DONE     = 2'd0,
      ST_NO_ROOM  = 2'd1,
      ST_BAD_PAGE = 2'd2
   } status_type;

   // controller to datapath
   typedef struct packed {
      logic load_req;    // capture request beat
      logic scan_start;  // rewind scan index
      logic scan_issue;  // read bitmap of next page in creation order
      logic scan_alloc;  // take lowest clear slot of the page just read
      logic new_page;    // open the lowest unused handle, give slot 0
      logic no_room;     // answer no room
      logic free_rd;     // read bitmap of the page named by the free
      logic free_wr;     // clear the slot, release the page if now empty
      logic bad_free;    // answer page not live
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic rd_valid;    // scan read data present this cycle
      logic hit;         // that page has a clear slot
      logic issue_more;  // pages left to read in creation order
      logic handle_free; // some handle not live
      logic page_ok;     // page named by the free is live
   } stat_type;

endpackage

// ===== rtl/pbsa_ctrl.sv =====
// controller state machine of the paged bitmap slot allocator
`timescale 1ns / 1ps

module pbsa_ctrl import pbsa_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   input  logic     req_op,
   input  stat_type stat,
   output cmd_type  cmd,
   output logic     busy
);

   typedef enum logic [3:0] {
      S_IDLE    = 4'b0001,
      S_SCAN    = 4'b0010,
      S_FREE_RD = 4'b0100,
      S_FREE_WR = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load_req = 1'b1;
               if (req_op == OP_FREE) begin
                  state_in = S_FREE_RD;
               end else begin
                  cmd.scan_start = 1'b1;
                  state_in       = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            priority if (stat.rd_valid && stat.hit) begin
               cmd.scan_alloc = 1'b1;
               state_in       = S_IDLE;
            end else if (stat.issue_more) begin
               cmd.scan_issue = 1'b1;
            end else if (!stat.rd_valid) begin
               if (stat.handle_free) cmd.new_page = 1'b1;
               else                  cmd.no_room  = 1'b1;
               state_in = S_IDLE;
            end else begin
               // last page read was full, let the read stage drain
               state_in = S_SCAN;
            end
         end
         S_FREE_RD: begin
            if (stat.page_ok) begin
               cmd.free_rd = 1'b1;
               state_in    = S_FREE_WR;
            end else begin
               cmd.bad_free = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_FREE_WR: begin
            cmd.free_wr = 1'b1;
            state_in    = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign busy = (state_ff != S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

endmodule

// ===== rtl/pbsa_datapath.sv =====
// bitmap memory, page order list, scan pipeline and result registers
`timescale 1ns / 1ps

module pbsa_datapath import pbsa_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  cmd_type  cmd,
   output stat_type stat,
   input  page_type req_page_index,
   input  slot_type req_slot_index,
   output logic     rsp_valid,
   output logic [1:0] rsp_status,
   output page_type rsp_got_page,
   output slot_type rsp_got_slot,
   output logic     rsp_page_released
);

   function automatic slot_type onehot_to_slot(input occ_type v);
      slot_type r;
      r = '0;
      for (int i = 0; i < SLOTS_PER_PAGE; i++)
         if (v[i]) r = r | slot_type'(i);
      return r;
   endfunction

   function automatic page_type onehot_to_page(input logic [MAX_PAGES-1:0] v);
      page_type r;
      r = '0;
      for (int i = 0; i < MAX_PAGES; i++)
         if (v[i]) r = r | page_type'(i);
      return r;
   endfunction

   // bitmap store, one row per handle
   occ_type                occ_ff [MAX_PAGES];
   logic [MAX_PAGES-1:0]   occ_ok_ff, occ_ok_in;
   logic                   mem_we, mem_re;
   page_type               mem_waddr, mem_raddr;
   occ_type                mem_wdata;

   // read stage
   occ_type    rd_raw_ff;
   logic       rd_ok_ff;
   page_type   rd_page_ff;
   logic       rd_valid_ff;

   // page bookkeeping
   logic [MAX_PAGES-1:0] live_ff, live_in;
   page_type   order_ff [MAX_PAGES];
   page_type   order_in [MAX_PAGES];
   count_type  count_ff, count_in;
   count_type  issue_ff, issue_in;

   page_type   req_page_ff;
   slot_type   req_slot_ff;

   logic       rsp_valid_ff, rsp_valid_in;
   status_type rsp_status_ff, rsp_status_in;
   page_type   rsp_page_ff, rsp_page_in;
   slot_type   rsp_slot_ff, rsp_slot_in;
   logic       rsp_rel_ff, rsp_rel_in;

   occ_type    occ_rd, free_bits, low_bit, clr_bits;
   slot_type   alloc_slot;
   logic       empty;
   logic [MAX_PAGES-1:0] free_h, low_h, after;
   page_type   new_h;

   assign occ_rd     = rd_ok_ff ? rd_raw_ff : '0;
   assign free_bits  = ~occ_rd;
   assign low_bit    = free_bits & (~free_bits + occ_type'(1));
   assign alloc_slot = onehot_to_slot(low_bit);
   assign clr_bits   = occ_rd & ~(occ_type'(1) << req_slot_ff);
   assign empty      = ~|clr_bits;

   assign free_h = ~live_ff;
   assign low_h  = free_h & (~free_h + {{(MAX_PAGES-1){1'b0}}, 1'b1});
   assign new_h  = onehot_to_page(low_h);

   assign stat.rd_valid    = rd_valid_ff;
   assign stat.hit         = |free_bits;
   assign stat.issue_more  = (issue_ff < count_ff);
   assign stat.handle_free = |free_h;
   assign stat.page_ok     = live_ff[req_page_ff];

   // memory port selection
   always_comb begin
      mem_re    = cmd.scan_issue | cmd.free_rd;
      mem_raddr = cmd.scan_issue ? order_ff[issue_ff[PAGE_W-1:0]] : req_page_ff;
      mem_we    = 1'b0;
      mem_waddr = rd_page_ff;
      mem_wdata = occ_rd | low_bit;
      priority if (cmd.scan_alloc) begin
         mem_we = 1'b1;
      end else if (cmd.new_page) begin
         mem_we    = 1'b1;
         mem_waddr = new_h;
         mem_wdata = occ_type'(1);
      end else if (cmd.free_wr) begin
         mem_we    = 1'b1;
         mem_wdata = clr_bits;
      end else begin
         mem_we = 1'b0;
      end
   end

   // positions at or after the released handle in the order list
   always_comb begin : find_pos
      logic seen;
      seen = 1'b0;
      for (int k = 0; k < MAX_PAGES; k++) begin
         if ((COUNT_W'(k) < count_ff) && (order_ff[k] == req_page_ff)) seen = 1'b1;
         after[k] = seen;
      end
   end

   always_comb begin
      occ_ok_in = occ_ok_ff;
      live_in   = live_ff;
      count_in  = count_ff;
      order_in  = order_ff;
      issue_in  = issue_ff;
      if (mem_we) occ_ok_in[mem_waddr] = 1'b1;
      if (cmd.scan_start) issue_in = '0;
      else if (cmd.scan_issue) issue_in = issue_ff + COUNT_W'(1);
      if (cmd.new_page) begin
         live_in[new_h]                       = 1'b1;
         order_in[count_ff[PAGE_W-1:0]]       = new_h;
         count_in                             = count_ff + COUNT_W'(1);
      end
      if (cmd.free_wr && empty) begin
         live_in[req_page_ff] = 1'b0;
         count_in             = count_ff - COUNT_W'(1);
         for (int k = 0; k < MAX_PAGES - 1; k++)
            if (after[k]) order_in[k] = order_ff[k+1];
      end
   end

   always_comb begin
      rsp_valid_in  = cmd.scan_alloc | cmd.new_page | cmd.no_room | cmd.free_wr |
                      cmd.bad_free;
      rsp_status_in = ST_DONE;
      rsp_page_in   = '0;
      rsp_slot_in   = '0;
      rsp_rel_in    = 1'b0;
      priority if (cmd.scan_alloc) begin
         rsp_page_in = rd_page_ff;
         rsp_slot_in = alloc_slot;
      end else if (cmd.new_page) begin
         rsp_page_in = new_h;
      end else if (cmd.no_room) begin
         rsp_status_in = ST_NO_ROOM;
      end else if (cmd.bad_free) begin
         rsp_status_in = ST_BAD_PAGE;
      end else if (cmd.free_wr) begin
         rsp_rel_in = empty;
      end else begin
         rsp_rel_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) occ_ff[mem_waddr] <= mem_wdata;
      if (mem_re) begin
         rd_raw_ff  <= occ_ff[mem_raddr];
         rd_ok_ff   <= occ_ok_ff[mem_raddr];
         rd_page_ff <= mem_raddr;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_page_ff <= req_page_index;
         req_slot_ff <= req_slot_index;
      end
      order_ff      <= order_in;
      issue_ff      <= issue_in;
      rsp_status_ff <= rsp_status_in;
      rsp_page_ff   <= rsp_page_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_rel_ff    <= rsp_rel_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ok_ff    <= '0;
         live_ff      <= '0;
         count_ff     <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         occ_ok_ff    <= occ_ok_in;
         live_ff      <= live_in;
         count_ff     <= count_in;
         rd_valid_ff  <= cmd.scan_issue;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_got_page      = rsp_page_ff;
   assign rsp_got_slot      = rsp_slot_ff;
   assign rsp_page_released = rsp_rel_ff;

endmodule

// ===== rtl/paged_bitmap_slot_allocator_top.sv =====
// top level of the paged bitmap slot allocator: controller plus datapath
// a free reads the bitmap, then clears the slot; a free of a page not live is refused;
//   an allocate takes the first live page with room, else a new page, else no room
// throughput: one beat at a time; busy drops in the cycle the result strobe shows
// reset: synchronous, active high; every page free, no live page, busy low
// results are strobed for one cycle on rsp_valid, the receiver cannot stall
`timescale 1ns / 1ps

module paged_bitmap_slot_allocator_top import pbsa_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   // request beat, taken when start is high and busy is low
   input  logic       start,
   output logic       busy,
   input  logic       req_op,
   input  logic [3:0] req_page_index,
   input  logic [6:0] req_slot_index,
   // result beat, one cycle per strobe
   output logic       rsp_valid,
   output logic [1:0] rsp_status,
   output logic [3:0] rsp_got_page,
   output logic [6:0] rsp_got_slot,
   output logic       rsp_page_released
);

   cmd_type  cmd;
   stat_type stat;

   // sequencing: scan loop, new page decision, free read-modify-write
   pbsa_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .req_op (req_op),
      .stat   (stat),
      .cmd    (cmd),
      .busy   (busy)
   );

   // bitmap memory with registered read, order list, lowest-clear-slot encoder
   pbsa_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_page_index    (req_page_index),
      .req_slot_index    (req_slot_index),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_got_page      (rsp_got_page),
      .rsp_got_slot      (rsp_got_slot),
      .rsp_page_released (rsp_page_released)
   );

endmodule

// ===== rtl/pbsa_checker.sv =====
// port level checker of the paged bitmap slot allocator and its bind
`timescale 1ns / 1ps

module pbsa_checker import pbsa_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic       rsp_valid,
   input logic [1:0] rsp_status,
   input logic [3:0] rsp_got_page,
   input logic [6:0] rsp_got_slot,
   input logic       rsp_page_released
);

   // an accepted beat raises busy
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("busy not raised after accepted beat");

   // result strobe comes only once the block is free again, never back to back
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy ##1 !rsp_valid)
      else $error("result strobe overlaps work");

   // failed requests carry no handle or slot
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_DONE) |->
         rsp_got_page == '0 && rsp_got_slot == '0 && !rsp_page_released)
      else $error("failed result carries payload");

   // a release only comes from a successful free
   a_release_free: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_page_released |->
         rsp_status == ST_DONE && rsp_got_page == '0 && rsp_got_slot == '0)
      else $error("release on a non-free result");

endmodule

bind paged_bitmap_slot_allocator_top pbsa_checker u_checker (.*);
